[sv/rhc_pkg.sv]
// Package for the RGB/HSV color converter: fixed-point widths, opcodes,
// pipeline control struct and the constant lookup tables built at elaboration.
// No dependencies; every other file of the block imports it.
package rhc_pkg;

    localparam int CHANNEL_MAX     = 15;
    localparam int CH_W            = 4;
    localparam int CH_TOP          = (1 << CH_W) - 1;
    localparam int SV_W            = 8;
    localparam int FX_SHIFT        = 8;
    localparam int FX_ONE          = 1 << FX_SHIFT;
    localparam int SV_MAX          = 255;
    localparam int HUE_MAX         = 255;
    localparam int HUE_STEP        = (6 << FX_SHIFT) / HUE_MAX;
    localparam int ROUND_HALF      = 128;
    localparam int SMALL_LIMIT     = 3;
    localparam int PIPE_DEPTH      = 5;

    // A normalized 8.8 value lies in 0..FX_ONE.
    localparam int NV_W            = FX_SHIFT + 1;
    // Largest reciprocal 65536/(max-min); the smallest difference is one channel step.
    localparam int DIFF_W          = $clog2(((FX_ONE << FX_SHIFT) / (FX_ONE / CHANNEL_MAX)) + 1);
    // Raw hue lies in -FX_ONE..5*FX_ONE.
    localparam int HS_W            = NV_W + 3;
    localparam int HABS_W          = NV_W + 2;
    // Division of the hue magnitude by HUE_STEP as a multiply by a rounded-up
    // reciprocal; exact for magnitudes up to 5*FX_ONE.
    localparam int HUE_RECIP_SHIFT = 13;
    localparam int HUE_RECIP       = ((1 << HUE_RECIP_SHIFT) / HUE_STEP) + 1;
    localparam int RECIP_W         = $clog2(HUE_RECIP + 1);
    localparam int HF_W            = SV_W + $clog2(HUE_STEP + 1);
    localparam int SECT_W          = HF_W - FX_SHIFT;
    localparam int CH_RND_W        = NV_W + $clog2(CHANNEL_MAX + 1);
    localparam int SV_RND_W        = NV_W + SV_W;

    typedef logic [NV_W-1:0] t_nval;
    typedef logic [(1 << CH_W)-1:0][NV_W-1:0] t_ch_tab;
    typedef logic [(1 << (2 * CH_W))-1:0][DIFF_W-1:0] t_diff_tab;
    typedef logic [(1 << (2 * CH_W))-1:0][SV_W-1:0] t_sat_tab;
    typedef logic [(1 << SV_W)-1:0][NV_W-1:0] t_sv_tab;

    typedef enum logic {
        OP_TO_HSV = 1'b0,
        OP_TO_RGB = 1'b1
    } t_op;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
        logic                  out_valid;
        t_op                   out_op;
    } t_pipe_ctl;

    // Unsigned long division by shift and subtract; used only while the
    // tables below are built, for non-negative operands.
    function automatic int fx_udiv(input int num, input int den);
        int quo;
        int rem;
        quo = 0;
        rem = 0;
        for (int k = 31; k >= 0; k--) begin
            rem = (rem << 1) | ((num >> k) & 1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (1 << k);
            end
        end
        return quo;
    endfunction

    function automatic t_ch_tab build_ch_tab();
        t_ch_tab tab;
        for (int i = 0; i < (1 << CH_W); i++) begin
            tab[i] = t_nval'(fx_udiv(i << FX_SHIFT, CHANNEL_MAX));
        end
        return tab;
    endfunction

    // Indexed by {max code, min code}: the 8.8 reciprocal of max-min.
    function automatic t_diff_tab build_diff_tab();
        t_diff_tab tab;
        int        mx;
        int        mn;
        for (int hi = 0; hi < (1 << CH_W); hi++) begin
            for (int lo = 0; lo < (1 << CH_W); lo++) begin
                mx = fx_udiv(hi << FX_SHIFT, CHANNEL_MAX);
                mn = fx_udiv(lo << FX_SHIFT, CHANNEL_MAX);
                if (mx > mn) begin
                    tab[hi * (1 << CH_W) + lo] = DIFF_W'(fx_udiv(FX_ONE << FX_SHIFT, mx - mn));
                end else begin
                    tab[hi * (1 << CH_W) + lo] = '0;
                end
            end
        end
        return tab;
    endfunction

    // Indexed by {max code, min code}: saturation already rounded to 0..255.
    function automatic t_sat_tab build_sat_tab();
        t_sat_tab tab;
        int       mx;
        int       mn;
        int       diff;
        int       den;
        int       s;
        int       t;
        for (int hi = 0; hi < (1 << CH_W); hi++) begin
            for (int lo = 0; lo < (1 << CH_W); lo++) begin
                mx = fx_udiv(hi << FX_SHIFT, CHANNEL_MAX);
                mn = fx_udiv(lo << FX_SHIFT, CHANNEL_MAX);
                s  = 0;
                if (mx > mn) begin
                    diff = fx_udiv(FX_ONE << FX_SHIFT, mx - mn);
                    den  = (diff * mx) >> FX_SHIFT;
                    if (den != 0) begin
                        s = fx_udiv(FX_ONE << FX_SHIFT, den);
                    end
                end
                t = (s * SV_MAX + ROUND_HALF) >> FX_SHIFT;
                if (t > SV_MAX) begin
                    t = SV_MAX;
                end
                tab[hi * (1 << CH_W) + lo] = SV_W'(t);
            end
        end
        return tab;
    endfunction

    function automatic t_sv_tab build_sv_tab();
        t_sv_tab tab;
        for (int i = 0; i < (1 << SV_W); i++) begin
            tab[i] = t_nval'(fx_udiv(i << FX_SHIFT, SV_MAX));
        end
        return tab;
    endfunction

    localparam t_ch_tab   CH_NORM_TAB = build_ch_tab();
    localparam t_diff_tab DIFF_TAB    = build_diff_tab();
    localparam t_sat_tab  SAT_TAB     = build_sat_tab();
    localparam t_sv_tab   SV_NORM_TAB = build_sv_tab();

endpackage

[sv/rhc_pipe_ctl.sv]
// Pipeline control for the color converter: per-stage valid bits, the opcode
// of each item in flight and the load enables that collapse bubbles.
// Depends on rhc_pkg.
module rhc_pipe_ctl import rhc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_op       i_op,
    input  logic      i_stall,
    output logic      o_stall,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] n_valid;
    logic [PIPE_DEPTH-1:0] r_op;
    logic [PIPE_DEPTH-1:0] load;

    // A stage takes new data when it is empty or when its content moves on.
    always_comb begin
        load[PIPE_DEPTH-1] = !r_valid[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            load[k] = !r_valid[k] || load[k+1];
        end
    end

    always_comb begin
        n_valid[0] = load[0] ? i_valid : r_valid[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_op[0] <= i_op;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (load[k]) begin
                r_op[k] <= r_op[k-1];
            end
        end
    end

    assign o_stall         = !load[0];
    assign o_ctl.load      = load;
    assign o_ctl.out_valid = r_valid[PIPE_DEPTH-1];
    assign o_ctl.out_op    = t_op'(r_op[PIPE_DEPTH-1]);

endmodule

[sv/rhc_to_hsv.sv]
// Five-stage datapath from 4-bit RGB to 8-bit HSV.
// Depends on rhc_pkg; stage loads come from rhc_pipe_ctl.
module rhc_to_hsv import rhc_pkg::*; (
    input  logic            i_clk,
    input  t_pipe_ctl       i_ctl,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output logic [SV_W-1:0] o_hue,
    output logic [SV_W-1:0] o_sat,
    output logic [SV_W-1:0] o_val
);

    typedef enum logic [1:0] {
        MAXC_RED   = 2'd0,
        MAXC_GREEN = 2'd1,
        MAXC_BLUE  = 2'd2
    } t_max_ch;

    // Stage 1: normalize, find max and min, look up reciprocal and saturation.
    t_max_ch         max_ch;
    logic [CH_W-1:0] max_code;
    logic [CH_W-1:0] min_code;
    t_nval           r1_r, r1_g, r1_b, r1_mx;
    logic [DIFF_W-1:0] r1_diff;
    logic [SV_W-1:0] r1_srnd;
    t_max_ch         r1_sel;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            max_ch   = MAXC_RED;
            max_code = i_red;
        end else if (i_green >= i_blue) begin
            max_ch   = MAXC_GREEN;
            max_code = i_green;
        end else begin
            max_ch   = MAXC_BLUE;
            max_code = i_blue;
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            min_code = i_red;
        end else if (i_green <= i_blue) begin
            min_code = i_green;
        end else begin
            min_code = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_r    <= CH_NORM_TAB[i_red];
            r1_g    <= CH_NORM_TAB[i_green];
            r1_b    <= CH_NORM_TAB[i_blue];
            r1_mx   <= CH_NORM_TAB[max_code];
            r1_diff <= DIFF_TAB[{max_code, min_code}];
            r1_srnd <= SAT_TAB[{max_code, min_code}];
            r1_sel  <= max_ch;
        end
    end

    // Stage 2: scaled distances from the max, and value rounding.
    logic [NV_W+DIFF_W-1:0] prod_r, prod_g, prod_b;
    logic [SV_RND_W-1:0]    v_sum;
    logic [NV_W-1:0]        v_quo;
    logic [SV_W-1:0]        n_val;
    t_nval                  r2_rc, r2_gc, r2_bc;
    t_max_ch                r2_sel;
    logic [SV_W-1:0]        r2_srnd;
    logic [SV_W-1:0]        r2_val;

    always_comb begin
        prod_r = (NV_W + DIFF_W)'(r1_mx - r1_r) * (NV_W + DIFF_W)'(r1_diff);
        prod_g = (NV_W + DIFF_W)'(r1_mx - r1_g) * (NV_W + DIFF_W)'(r1_diff);
        prod_b = (NV_W + DIFF_W)'(r1_mx - r1_b) * (NV_W + DIFF_W)'(r1_diff);
        v_sum  = SV_RND_W'(r1_mx) * SV_RND_W'(SV_MAX) + SV_RND_W'(ROUND_HALF);
        v_quo  = v_sum[FX_SHIFT +: NV_W];
        n_val  = (v_quo > NV_W'(SV_MAX)) ? SV_W'(SV_MAX) : v_quo[SV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_rc   <= prod_r[FX_SHIFT +: NV_W];
            r2_gc   <= prod_g[FX_SHIFT +: NV_W];
            r2_bc   <= prod_b[FX_SHIFT +: NV_W];
            r2_sel  <= r1_sel;
            r2_srnd <= r1_srnd;
            r2_val  <= n_val;
        end
    end

    // Stage 3: raw sector hue, split into sign and magnitude.
    logic signed [HS_W-1:0] h_raw;
    logic [HS_W-1:0]        h_mag;
    logic                   r3_neg;
    logic [HABS_W-1:0]      r3_habs;
    logic [SV_W-1:0]        r3_srnd;
    logic [SV_W-1:0]        r3_val;

    always_comb begin
        case (r2_sel)
            MAXC_RED: begin
                h_raw = HS_W'(r2_bc) - HS_W'(r2_gc);
            end
            MAXC_GREEN: begin
                h_raw = HS_W'(2 * FX_ONE) + HS_W'(r2_rc) - HS_W'(r2_bc);
            end
            default: begin
                h_raw = HS_W'(4 * FX_ONE) + HS_W'(r2_gc) - HS_W'(r2_rc);
            end
        endcase
        h_mag = h_raw[HS_W-1] ? HS_W'(-h_raw) : HS_W'(h_raw);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_neg  <= h_raw[HS_W-1];
            r3_habs <= h_mag[HABS_W-1:0];
            r3_srnd <= r2_srnd;
            r3_val  <= r2_val;
        end
    end

    // Stage 4: magnitude divided by the hue step, truncating.
    logic [HABS_W+RECIP_W-1:0] quo_prod;
    logic                      r4_neg;
    logic [SV_W-1:0]           r4_quo;
    logic [SV_W-1:0]           r4_srnd;
    logic [SV_W-1:0]           r4_val;

    assign quo_prod = (HABS_W + RECIP_W)'(r3_habs) * (HABS_W + RECIP_W)'(HUE_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_neg  <= r3_neg;
            r4_quo  <= quo_prod[HUE_RECIP_SHIFT +: SV_W];
            r4_srnd <= r3_srnd;
            r4_val  <= r3_val;
        end
    end

    // Stage 5: wrap a negative hue, drop the full-circle value, zero small results.
    logic [SV_W:0]   hue_wrap;
    logic [SV_W-1:0] n_hue;
    logic [SV_W-1:0] n_sat;
    logic [SV_W-1:0] r5_hue;
    logic [SV_W-1:0] r5_sat;
    logic [SV_W-1:0] r5_val;

    always_comb begin
        hue_wrap = r4_neg ? ((SV_W + 1)'(HUE_MAX) - (SV_W + 1)'(r4_quo))
                          : (SV_W + 1)'(r4_quo);
        n_hue    = (hue_wrap >= (SV_W + 1)'(HUE_MAX)) ? '0 : hue_wrap[SV_W-1:0];
        // No hue for an achromatic result, nor for a hue below SMALL_LIMIT.
        if (r4_srnd == '0 || n_hue < SV_W'(SMALL_LIMIT)) begin
            n_hue = '0;
        end
        n_sat = (r4_srnd < SV_W'(SMALL_LIMIT)) ? '0 : r4_srnd;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_hue <= n_hue;
            r5_sat <= n_sat;
            r5_val <= r4_val;
        end
    end

    assign o_hue = r5_hue;
    assign o_sat = r5_sat;
    assign o_val = r5_val;

endmodule

[sv/rhc_to_rgb.sv]
// Five-stage datapath from 8-bit HSV to 4-bit RGB.
// Depends on rhc_pkg; stage loads come from rhc_pipe_ctl.
module rhc_to_rgb import rhc_pkg::*; (
    input  logic            i_clk,
    input  t_pipe_ctl       i_ctl,
    input  logic [SV_W-1:0] i_hue,
    input  logic [SV_W-1:0] i_sat,
    input  logic [SV_W-1:0] i_val,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue
);

    typedef enum logic [SECT_W-1:0] {
        SEC_R_TO_Y = SECT_W'(0),
        SEC_Y_TO_G = SECT_W'(1),
        SEC_G_TO_C = SECT_W'(2),
        SEC_C_TO_B = SECT_W'(3),
        SEC_B_TO_M = SECT_W'(4),
        SEC_M_TO_R = SECT_W'(5)
    } t_sector;

    function automatic logic [CH_W-1:0] ch_round(input t_nval x);
        logic [CH_RND_W-1:0]          sum;
        logic [CH_RND_W-FX_SHIFT-1:0] quo;
        sum = CH_RND_W'(x) * CH_RND_W'(CHANNEL_MAX) + CH_RND_W'(ROUND_HALF);
        quo = sum[CH_RND_W-1:FX_SHIFT];
        return (quo > (CH_RND_W - FX_SHIFT)'(CH_TOP)) ? CH_W'(CH_TOP) : quo[CH_W-1:0];
    endfunction

    // Stage 1: normalize s and v, split the hue into sector and fraction.
    logic [SV_W-1:0]     hue_fix;
    logic [HF_W-1:0]     hue_frac;
    t_nval               r1_s, r1_v;
    logic [FX_SHIFT-1:0] r1_f;
    logic [SECT_W-1:0]   r1_sect;
    logic                r1_szero;

    always_comb begin
        hue_fix  = (i_hue == SV_W'(HUE_MAX)) ? '0 : i_hue;
        hue_frac = HF_W'(hue_fix) * HF_W'(HUE_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_s     <= SV_NORM_TAB[i_sat];
            r1_v     <= SV_NORM_TAB[i_val];
            r1_f     <= hue_frac[FX_SHIFT-1:0];
            r1_sect  <= hue_frac[HF_W-1:FX_SHIFT];
            r1_szero <= (SV_NORM_TAB[i_sat] == '0);
        end
    end

    // Stage 2: p, and the two saturation-weighted fractions.
    logic [2*NV_W-1:0] prod_p, prod_sf, prod_sg;
    t_nval             r2_p, r2_sf, r2_sg, r2_v;
    logic [SECT_W-1:0] r2_sect;
    logic              r2_szero;

    always_comb begin
        prod_p  = (2 * NV_W)'(r1_v) * (2 * NV_W)'(t_nval'(FX_ONE) - r1_s);
        prod_sf = (2 * NV_W)'(r1_s) * (2 * NV_W)'(r1_f);
        prod_sg = (2 * NV_W)'(r1_s) * (2 * NV_W)'(t_nval'(FX_ONE) - t_nval'(r1_f));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_p     <= prod_p[FX_SHIFT +: NV_W];
            r2_sf    <= prod_sf[FX_SHIFT +: NV_W];
            r2_sg    <= prod_sg[FX_SHIFT +: NV_W];
            r2_v     <= r1_v;
            r2_sect  <= r1_sect;
            r2_szero <= r1_szero;
        end
    end

    // Stage 3: q and t.
    logic [2*NV_W-1:0] prod_q, prod_t;
    t_nval             r3_p, r3_q, r3_t, r3_v;
    logic [SECT_W-1:0] r3_sect;
    logic              r3_szero;

    always_comb begin
        prod_q = (2 * NV_W)'(r2_v) * (2 * NV_W)'(t_nval'(FX_ONE) - r2_sf);
        prod_t = (2 * NV_W)'(r2_v) * (2 * NV_W)'(t_nval'(FX_ONE) - r2_sg);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_p     <= r2_p;
            r3_q     <= prod_q[FX_SHIFT +: NV_W];
            r3_t     <= prod_t[FX_SHIFT +: NV_W];
            r3_v     <= r2_v;
            r3_sect  <= r2_sect;
            r3_szero <= r2_szero;
        end
    end

    // Stage 4: sector selection; a grey input keeps v on all channels.
    t_nval n_cr, n_cg, n_cb;
    t_nval r4_cr, r4_cg, r4_cb;

    always_comb begin
        case (t_sector'(r3_sect))
            SEC_R_TO_Y: begin
                n_cr = r3_v; n_cg = r3_t; n_cb = r3_p;
            end
            SEC_Y_TO_G: begin
                n_cr = r3_q; n_cg = r3_v; n_cb = r3_p;
            end
            SEC_G_TO_C: begin
                n_cr = r3_p; n_cg = r3_v; n_cb = r3_t;
            end
            SEC_C_TO_B: begin
                n_cr = r3_p; n_cg = r3_q; n_cb = r3_v;
            end
            SEC_B_TO_M: begin
                n_cr = r3_t; n_cg = r3_p; n_cb = r3_v;
            end
            default: begin
                n_cr = r3_v; n_cg = r3_p; n_cb = r3_q;
            end
        endcase
        if (r3_szero) begin
            n_cr = r3_v;
            n_cg = r3_v;
            n_cb = r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_cr <= n_cr;
            r4_cg <= n_cg;
            r4_cb <= n_cb;
        end
    end

    // Stage 5: round each channel back to the output scale.
    logic [CH_W-1:0] r5_red, r5_green, r5_blue;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_red   <= ch_round(r4_cr);
            r5_green <= ch_round(r4_cg);
            r5_blue  <= ch_round(r4_cb);
        end
    end

    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

endmodule

[sv/rgb_hsv_converter_top.sv]
// Top level of the RGB/HSV color converter: pipeline control plus the two
// conversion datapaths. Depends on rhc_pkg, rhc_pipe_ctl, rhc_to_hsv, rhc_to_rgb.
//
// This block converts one color per item in either direction between 4-bit
// RGB and 8-bit HSV, with i_op selecting the direction (0 for RGB to HSV,
// 1 for HSV to RGB); the fields of the direction not chosen come out as zero.
// It is a five-stage pipeline that accepts a new item on every clock while
// o_stall is low: o_valid rises once the item reaches the fifth stage register,
// and the sustained rate is one item per cycle while i_stall is low; the five
// stages are set by the chain of dependent multiplies in the HSV to RGB path
// and by the divide-by-six step of the hue in the RGB to HSV path. Back-pressure
// through i_stall holds the output item in place while empty stages behind it
// keep filling, so o_stall rises only when all five stages hold items and the
// output is held back. The block keeps no state between items, has no
// configuration, and needs no clearing pass after reset.
module rgb_hsv_converter_top import rhc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_op,
    input  logic [CH_W-1:0] i_red_in,
    input  logic [CH_W-1:0] i_green_in,
    input  logic [CH_W-1:0] i_blue_in,
    input  logic [SV_W-1:0] i_hue_in,
    input  logic [SV_W-1:0] i_sat_in,
    input  logic [SV_W-1:0] i_val_in,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [SV_W-1:0] o_hue_out,
    output logic [SV_W-1:0] o_sat_out,
    output logic [SV_W-1:0] o_val_out,
    output logic [CH_W-1:0] o_red_out,
    output logic [CH_W-1:0] o_green_out,
    output logic [CH_W-1:0] o_blue_out
);

    t_pipe_ctl       pipe_ctl;
    logic [SV_W-1:0] hsv_hue, hsv_sat, hsv_val;
    logic [CH_W-1:0] rgb_red, rgb_green, rgb_blue;
    logic            out_is_hsv;

    // Valid bits and the opcode travel here; both datapaths load in step with them.
    rhc_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (t_op'(i_op)),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_ctl   (pipe_ctl)
    );

    // Both directions are computed for every item; the opcode picks the result.
    rhc_to_hsv u_to_hsv (
        .i_clk   (i_clk),
        .i_ctl   (pipe_ctl),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_hue   (hsv_hue),
        .o_sat   (hsv_sat),
        .o_val   (hsv_val)
    );

    rhc_to_rgb u_to_rgb (
        .i_clk   (i_clk),
        .i_ctl   (pipe_ctl),
        .i_hue   (i_hue_in),
        .i_sat   (i_sat_in),
        .i_val   (i_val_in),
        .o_red   (rgb_red),
        .o_green (rgb_green),
        .o_blue  (rgb_blue)
    );

    // The fields of the direction not chosen are forced to zero.
    assign out_is_hsv  = (pipe_ctl.out_op == OP_TO_HSV);
    assign o_valid     = pipe_ctl.out_valid;
    assign o_hue_out   = out_is_hsv ? hsv_hue : '0;
    assign o_sat_out   = out_is_hsv ? hsv_sat : '0;
    assign o_val_out   = out_is_hsv ? hsv_val : '0;
    assign o_red_out   = out_is_hsv ? '0 : rgb_red;
    assign o_green_out = out_is_hsv ? '0 : rgb_green;
    assign o_blue_out  = out_is_hsv ? '0 : rgb_blue;

endmodule

[sv/rhc_checker.sv]
// Port-level checks for the color converter, bound to the top level.
// Depends on rhc_pkg and on the port names of rgb_hsv_converter_top.
module rhc_checker import rhc_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_stall,
    input logic            o_stall,
    input logic [SV_W-1:0] o_hue_out,
    input logic [SV_W-1:0] o_sat_out,
    input logic [SV_W-1:0] o_val_out,
    input logic [CH_W-1:0] o_red_out,
    input logic [CH_W-1:0] o_green_out,
    input logic [CH_W-1:0] o_blue_out
);

    // A result that is held back stays offered.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output item dropped while stalled");

    // The input side only stalls when the output is full and held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // An item carries results of one direction only.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_red_out != '0 || o_green_out != '0 || o_blue_out != '0))
        |-> (o_hue_out == '0 && o_sat_out == '0 && o_val_out == '0))
        else $error("RGB and HSV fields both nonzero");

    // Hue never reaches the full circle, and small hue or saturation is zeroed.
    a_hsv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_out != SV_W'(HUE_MAX)
                     && (o_hue_out == '0 || o_hue_out >= SV_W'(SMALL_LIMIT))
                     && (o_sat_out == '0 || o_sat_out >= SV_W'(SMALL_LIMIT))))
        else $error("hue or saturation out of range");

endmodule

bind rgb_hsv_converter_top rhc_checker u_rhc_checker (.*);

[tb/rgb_hsv_converter_top_tb.sv]
// Self-checking testbench for rgb_hsv_converter_top: random idle and stall traffic on
// both item channels, with every result checked against a predictor kept in the bench.
// Depends on rhc_pkg and on the converter RTL.
module rgb_hsv_converter_top_tb import rhc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF_NS   = 10;
    localparam int  RESET_CYCLES  = 7;
    localparam int  HOLD_CYCLES   = 60;
    localparam int  MAX_GAP       = 18;
    // The slowest correct run of roughly 800 items, each behind the longest sender
    // gap and receiver stall, takes about 0.7 ms. The limit is several times that.
    localparam time RUN_LIMIT     = 5ms;

    // One input item and one result item, field by field.
    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [SV_W-1:0] hue;
        logic [SV_W-1:0] sat;
        logic [SV_W-1:0] val;
    } t_color_item;

    typedef struct packed {
        logic [SV_W-1:0] hue;
        logic [SV_W-1:0] sat;
        logic [SV_W-1:0] val;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color_result;

    // How the receiving side treats o_valid.
    typedef enum int {
        SINK_FREE,
        SINK_RANDOM,
        SINK_HOLD
    } t_sink_mode;

    // The scoreboard predicts the converted color of every accepted item and
    // keeps those colors in arrival order until the matching result shows up.
    class t_color_scoreboard;
        t_color_result expected_colors[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // 8.8 product; every operand in this datapath is non-negative.
        static function int fx_product(int a, int b);
            return (a * b) >> FX_SHIFT;
        endfunction

        static function int sv_rescale(int x);
            int t;
            if (x < 0) begin
                x = 0;
            end
            t = (x * SV_MAX + ROUND_HALF) / FX_ONE;
            return (t > SV_MAX) ? SV_MAX : t;
        endfunction

        static function int ch_rescale(int x);
            int t;
            if (x < 0) begin
                x = 0;
            end
            t = (x * CHANNEL_MAX + ROUND_HALF) / FX_ONE;
            return (t > 15) ? 15 : t;
        endfunction

        static function t_color_result convert_to_hsv(t_color_item it);
            t_color_result res;
            int            r, g, b, mx, mn, diff, den, s, h, rc, gc, bc;
            res  = '0;
            r    = it.red * FX_ONE / CHANNEL_MAX;
            g    = it.green * FX_ONE / CHANNEL_MAX;
            b    = it.blue * FX_ONE / CHANNEL_MAX;
            mx   = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
            mn   = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
            s    = 0;
            h    = 0;
            diff = 0;
            // A grey input leaves the saturation at zero.
            if (mx != mn) begin
                diff = (FX_ONE << FX_SHIFT) / (mx - mn);
                den  = fx_product(diff, mx);
                if (den != 0) begin
                    s = (FX_ONE << FX_SHIFT) / den;
                end
            end
            s = sv_rescale(s);
            if (s != 0) begin
                rc = fx_product(mx - r, diff);
                gc = fx_product(mx - g, diff);
                bc = fx_product(mx - b, diff);
                if (r == mx) begin
                    h = bc - gc;
                end else if (g == mx) begin
                    h = 2 * FX_ONE + rc - bc;
                end else begin
                    h = 4 * FX_ONE + gc - rc;
                end
                // Signed division truncates toward zero; a negative hue wraps.
                h = h / HUE_STEP;
                if (h < 0) begin
                    h = h + HUE_MAX;
                end
                if (h >= HUE_MAX || h < 0) begin
                    h = 0;
                end
            end
            if (h < SMALL_LIMIT) begin
                h = 0;
            end
            if (s < SMALL_LIMIT) begin
                s = 0;
            end
            res.hue = SV_W'(h);
            res.sat = SV_W'(s);
            res.val = SV_W'(sv_rescale(mx));
            return res;
        endfunction

        static function t_color_result convert_to_rgb(t_color_item it);
            t_color_result res;
            int            h, s, v, r, g, b, hf, sect, f, p, q, tv;
            res = '0;
            h   = it.hue;
            s   = it.sat * FX_ONE / SV_MAX;
            v   = it.val * FX_ONE / SV_MAX;
            r   = v;
            g   = v;
            b   = v;
            if (h >= HUE_MAX) begin
                h = 0;
            end
            if (s != 0) begin
                hf   = h * HUE_STEP;
                sect = hf >> FX_SHIFT;
                f    = hf - sect * FX_ONE;
                p    = fx_product(v, FX_ONE - s);
                q    = fx_product(v, FX_ONE - fx_product(s, f));
                tv   = fx_product(v, FX_ONE - fx_product(s, FX_ONE - f));
                case (sect)
                    0: begin r = v;  g = tv; b = p;  end
                    1: begin r = q;  g = v;  b = p;  end
                    2: begin r = p;  g = v;  b = tv; end
                    3: begin r = p;  g = q;  b = v;  end
                    4: begin r = tv; g = p;  b = v;  end
                    default: begin r = v; g = p; b = q; end
                endcase
            end
            res.red   = CH_W'(ch_rescale(r));
            res.green = CH_W'(ch_rescale(g));
            res.blue  = CH_W'(ch_rescale(b));
            return res;
        endfunction

        function void note_color_in(t_color_item it);
            if (it.op == OP_TO_HSV) begin
                expected_colors.push_back(convert_to_hsv(it));
            end else begin
                expected_colors.push_back(convert_to_rgb(it));
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_color_out(t_color_result got);
            t_color_result want;
            if (expected_colors.size() == 0) begin
                $display("%0t: result with no item outstanding, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_colors.pop_front();
            compare_field("hue_out",   want.hue,   got.hue);
            compare_field("sat_out",   want.sat,   got.sat);
            compare_field("val_out",   want.val,   got.val);
            compare_field("red_out",   want.red,   got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out",  want.blue,  got.blue);
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic            i_op;
    logic [CH_W-1:0] i_red_in;
    logic [CH_W-1:0] i_green_in;
    logic [CH_W-1:0] i_blue_in;
    logic [SV_W-1:0] i_hue_in;
    logic [SV_W-1:0] i_sat_in;
    logic [SV_W-1:0] i_val_in;
    logic            o_valid;
    logic            i_stall;
    logic [SV_W-1:0] o_hue_out;
    logic [SV_W-1:0] o_sat_out;
    logic [SV_W-1:0] o_val_out;
    logic [CH_W-1:0] o_red_out;
    logic [CH_W-1:0] o_green_out;
    logic [CH_W-1:0] o_blue_out;

    t_color_scoreboard scoreboard = new();
    t_sink_mode        sink_mode  = SINK_RANDOM;

    rgb_hsv_converter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_hue_in    (i_hue_in),
        .i_sat_in    (i_sat_in),
        .i_val_in    (i_val_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hue_out   (o_hue_out),
        .o_sat_out   (o_sat_out),
        .o_val_out   (o_val_out),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    // 20 ns clock.
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Watch both channels at every rising edge. All bench inputs change through
    // nonblocking assignments, so the values seen here are the ones the block
    // saw at the same edge. The item noted and the result checked at one edge
    // are never the same item, since an item passes the stage registers first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                scoreboard.note_color_in('{op: t_op'(i_op), red: i_red_in, green: i_green_in,
                                           blue: i_blue_in, hue: i_hue_in, sat: i_sat_in,
                                           val: i_val_in});
            end
            if (o_valid && !i_stall) begin
                scoreboard.check_color_out('{hue: o_hue_out, sat: o_sat_out, val: o_val_out,
                                             red: o_red_out, green: o_green_out,
                                             blue: o_blue_out});
            end
        end
    end

    // Receiving side. In random mode it alternates random-length stall bursts with
    // free stretches, so stalls land on every pipeline phase. Hold mode keeps
    // i_stall high for a long stretch, which fills the pipeline and pushes o_stall
    // back to the sender; afterwards it returns to random mode.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            case (sink_mode)
                SINK_HOLD: begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    i_stall   <= 1'b0;
                    sink_mode = SINK_RANDOM;
                end
                SINK_RANDOM: begin
                    if ($urandom_range(0, 4) == 0) begin
                        i_stall <= 1'b1;
                        repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
                        i_stall <= 1'b0;
                    end else begin
                        i_stall <= 1'b0;
                        repeat ($urandom_range(0, 12)) @(posedge i_clk);
                    end
                end
                default: begin
                    i_stall <= 1'b0;
                end
            endcase
        end
    end

    // Offer one item and hold it steady until the block takes it. Called at a
    // rising edge; returns at the edge where the item was accepted. With gaps
    // enabled, the sender sometimes idles for a random stretch first.
    task automatic offer_color(input t_color_item it, input bit gaps_on);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= it.op;
        i_red_in   <= it.red;
        i_green_in <= it.green;
        i_blue_in  <= it.blue;
        i_hue_in   <= it.hue;
        i_sat_in   <= it.sat;
        i_val_in   <= it.val;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait until every expected color has come back. The
    // first edge lets the monitor note an item accepted at the calling edge.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    // Every field gets random content, including those of the unused direction.
    function automatic t_color_item random_color();
        t_color_item it;
        it.op    = t_op'($urandom_range(0, 1));
        it.red   = CH_W'($urandom);
        it.green = CH_W'($urandom);
        it.blue  = CH_W'($urandom);
        it.hue   = SV_W'($urandom);
        it.sat   = SV_W'($urandom);
        it.val   = SV_W'($urandom);
        return it;
    endfunction

    function automatic t_color_item make_rgb(input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b);
        t_color_item it;
        it       = random_color();
        it.op    = OP_TO_HSV;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        return it;
    endfunction

    function automatic t_color_item make_hsv(input logic [SV_W-1:0] h,
                                             input logic [SV_W-1:0] s,
                                             input logic [SV_W-1:0] v);
        t_color_item it;
        it     = random_color();
        it.op  = OP_TO_RGB;
        it.hue = h;
        it.sat = s;
        it.val = v;
        return it;
    endfunction

    // Main sequence.
    initial begin
        int n;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_op       <= OP_TO_HSV;
        i_red_in   <= '0;
        i_green_in <= '0;
        i_blue_in  <= '0;
        i_hue_in   <= '0;
        i_sat_in   <= '0;
        i_val_in   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed RGB to HSV items: black, white and mid grey (saturation and
        // hue zero), the primaries and secondaries, a red-dominant color whose
        // hue goes negative and wraps, one with a tiny hue that is forced to
        // zero, and a nearly grey color with weak saturation.
        offer_color(make_rgb(4'd0, 4'd0, 4'd0), 1'b1);
        offer_color(make_rgb(4'd15, 4'd15, 4'd15), 1'b1);
        offer_color(make_rgb(4'd7, 4'd7, 4'd7), 1'b1);
        offer_color(make_rgb(4'd15, 4'd0, 4'd0), 1'b1);
        offer_color(make_rgb(4'd0, 4'd15, 4'd0), 1'b1);
        offer_color(make_rgb(4'd0, 4'd0, 4'd15), 1'b1);
        offer_color(make_rgb(4'd15, 4'd15, 4'd0), 1'b1);
        offer_color(make_rgb(4'd0, 4'd15, 4'd15), 1'b1);
        offer_color(make_rgb(4'd15, 4'd0, 4'd15), 1'b1);
        offer_color(make_rgb(4'd15, 4'd0, 4'd1), 1'b1);
        offer_color(make_rgb(4'd15, 4'd1, 4'd0), 1'b1);
        offer_color(make_rgb(4'd15, 4'd14, 4'd14), 1'b1);

        // Directed HSV to RGB items: hue 0, hue 255 taken as 0, hue 254, the first
        // hue of every sector and the last of four, zero saturation and zero value.
        offer_color(make_hsv(8'd0, 8'd255, 8'd255), 1'b1);
        offer_color(make_hsv(8'd255, 8'd255, 8'd255), 1'b1);
        offer_color(make_hsv(8'd254, 8'd255, 8'd255), 1'b1);
        offer_color(make_hsv(8'd43, 8'd200, 8'd255), 1'b1);
        offer_color(make_hsv(8'd85, 8'd255, 8'd128), 1'b1);
        offer_color(make_hsv(8'd86, 8'd255, 8'd200), 1'b1);
        offer_color(make_hsv(8'd128, 8'd100, 8'd255), 1'b1);
        offer_color(make_hsv(8'd170, 8'd255, 8'd255), 1'b1);
        offer_color(make_hsv(8'd171, 8'd1, 8'd255), 1'b1);
        offer_color(make_hsv(8'd213, 8'd255, 8'd77), 1'b1);
        offer_color(make_hsv(8'd214, 8'd180, 8'd255), 1'b1);
        offer_color(make_hsv(8'd100, 8'd0, 8'd180), 1'b1);
        offer_color(make_hsv(8'd60, 8'd255, 8'd0), 1'b1);

        // Random items with idling on both sides; every third stretch of 40
        // items runs without sender gaps.
        for (n = 0; n < 300; n++) begin
            offer_color(random_color(), ((n / 40) % 3) != 2);
        end

        // Long receiver hold while the sender keeps offering back to back, so
        // the pipeline fills and o_stall rises.
        sink_mode = SINK_HOLD;
        for (n = 0; n < 40; n++) begin
            offer_color(random_color(), 1'b0);
        end

        // Sender pauses until every expected color is back, then resumes.
        drain_pipeline();
        for (n = 0; n < 280; n++) begin
            offer_color(random_color(), ((n / 40) % 3) != 1);
        end

        // Final stretch at full rate with no idling on either side.
        sink_mode = SINK_FREE;
        for (n = 0; n < 150; n++) begin
            offer_color(random_color(), 1'b0);
        end

        drain_pipeline();
        // Keep clocking so that a stray extra result would still be seen.
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
            $display("rgb_hsv_converter_top_tb OK");
        end else begin
            $display("rgb_hsv_converter_top_tb NOT OK");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("rgb_hsv_converter_top_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
sv/rhc_pkg.sv
sv/rhc_pipe_ctl.sv
sv/rhc_to_hsv.sv
sv/rhc_to_rgb.sv
sv/rgb_hsv_converter_top.sv
sv/rhc_checker.sv
tb/rgb_hsv_converter_top_tb.sv
